[hw/rtl/fra_pkg.sv]
// fra_pkg: shared constants, the command enum and the status struct for the
// frame ring allocator. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package fra_pkg;
   localparam int SLICE_COUNT = 8;
   localparam int SLICE_W = $clog2(SLICE_COUNT);
   localparam logic [32:0] RING_MAX = 33'h1_0000_0000;
   localparam logic [32:0] BUF_RESET = 33'd16777216;
   localparam logic [32:0] USED_MAX = 33'h1_FFFF_FFFF;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_NOFIT = 2'd1;
   localparam logic [1:0] ST_NOSLICE = 2'd2;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_END = 1'b1;

   // Datapath commands from the controller.
   typedef enum logic [3:0] {
      CMD_NONE = 4'd0,
      CMD_ALLOC_SETUP = 4'd1,   // latch item, size, o0 division start
      CMD_DIV_STEP = 4'd2,      // one restoring division bit
      CMD_ALLOC_MID = 4'd3,     // after o0 = off % b: fit check, start retry div
      CMD_ALLOC_POST = 4'd4,    // after retry div: offset, start count*size multiply
      CMD_ALIGN_START = 4'd5,   // advance running offset, start off+al-1 / al
      CMD_SLICE_STEP = 4'd6,    // one slice overlap compare
      CMD_ALLOC_DONE = 4'd7,    // rounded offset, result out
      CMD_END_FREE = 4'd8,      // free signalled slices, start s % b
      CMD_END_CLOSE = 4'd9,     // close slice, open new one, result out
      CMD_MUL_STEP = 4'd10      // one step of count*size
   } cmd_type;

   typedef struct packed {
      logic div_busy;
      logic mul_busy;
      logic nofit;
      logic fast;
      logic slice_last;
   } status_type;
endpackage
`default_nettype wire

[hw/rtl/fra_if.sv]
// fra_if: valid/ready channel carrying a packed payload.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface fra_if #(parameter int W = 1);
   logic valid;
   logic ready;
   logic [W-1:0] data;
   modport source(output valid, output data, input ready);
   modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

[hw/rtl/frame_ring_allocator.sv]
// frame_ring_allocator: top level; joins controller, datapath and channels.
// Depends on fra_pkg, fra_if, fra_ctrl, fra_dp.
//
// Per-frame transient allocator over a ring buffer. One item at a time: an
// allocate word runs the bit-serial divider (64 steps each for offset modulo size,
// retry quotient and alignment round-up) plus up to 64 multiply steps and an
// eight-step slice walk. An end-frame word runs one 64-step modulo. A request
// that can never fit answers at the accepting edge and frees the input once the
// controller has gone from S_DIV0 back to idle and the answer has been taken. The
// buffer size register must be written only while idle; the block does not enforce it.
`timescale 1ns / 1ps
`default_nettype none
module frame_ring_allocator (
   input wire logic clock,
   input wire logic reset,
   fra_if.sink req,
   fra_if.source rsp,
   fra_if.sink csr
);
   fra_pkg::cmd_type cmd;
   fra_pkg::status_type stat;
   logic in_ready;

   assign req.ready = in_ready;
   assign csr.ready = 1'b1;

   fra_ctrl u_ctrl (
      .clock(clock), .reset(reset), .in_valid(req.valid), .in_op(req.data[0]),
      .in_ready(in_ready), .out_busy(rsp.valid), .stat(stat), .cmd(cmd)
   );

   // rsp.data: status[1:0], used_bytes[34:2], fenced[42:35], wait[50:43], offset[82:51]
   fra_dp u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .in_alloc_size(req.data[32:1]), .in_alignment(req.data[49:33]),
      .in_signaled_mask(req.data[57:50]),
      .cfg_we(csr.valid), .cfg_data(csr.data[32:0]),
      .out_valid(rsp.valid), .out_ready(rsp.ready),
      .out_aligned_offset(rsp.data[82:51]), .out_wait_mask(rsp.data[50:43]),
      .out_fenced_mask(rsp.data[42:35]), .out_used_bytes(rsp.data[34:2]),
      .out_status(rsp.data[1:0])
   );
endmodule
`default_nettype wire

[hw/rtl/fra_ctrl.sv]
// fra_ctrl: sequencing state machine of the frame ring allocator.
// Depends on fra_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fra_ctrl (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic in_valid,
   input  wire logic in_op,
   output logic in_ready,
   input  wire logic out_busy,
   input  fra_pkg::status_type stat,
   output fra_pkg::cmd_type cmd
);
   typedef enum logic [10:0] {
      S_IDLE = 11'b00000000001,
      S_DIV0 = 11'b00000000010,
      S_MID = 11'b00000000100,
      S_DIV1 = 11'b00000001000,
      S_POST = 11'b00000010000,
      S_MUL = 11'b00000100000,
      S_ALIGN = 11'b00001000000,
      S_SLICE = 11'b00010000000,
      S_DONE = 11'b00100000000,
      S_EDIV = 11'b01000000000,
      S_CLOSE = 11'b10000000000
   } state_type;
   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd = fra_pkg::CMD_NONE;
      in_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            in_ready = !out_busy;
            if (in_valid && !out_busy) begin
               if (in_op == fra_pkg::OP_ALLOC) begin
                  cmd = fra_pkg::CMD_ALLOC_SETUP;
                  state_in = S_DIV0;
               end else begin
                  cmd = fra_pkg::CMD_END_FREE;
                  state_in = S_EDIV;
               end
            end
         end
         S_DIV0: begin
            if (stat.nofit) state_in = S_IDLE;
            else if (stat.div_busy) cmd = fra_pkg::CMD_DIV_STEP;
            else state_in = S_MID;
         end
         S_MID: begin
            cmd = fra_pkg::CMD_ALLOC_MID;
            state_in = S_DIV1;
         end
         S_DIV1: begin
            if (stat.fast) state_in = S_POST;
            else if (stat.div_busy) cmd = fra_pkg::CMD_DIV_STEP;
            else state_in = S_POST;
         end
         S_POST: begin
            cmd = fra_pkg::CMD_ALLOC_POST;
            state_in = S_MUL;
         end
         S_MUL: begin
            if (stat.mul_busy) cmd = fra_pkg::CMD_MUL_STEP;
            else begin
               cmd = fra_pkg::CMD_ALIGN_START;
               state_in = S_ALIGN;
            end
         end
         S_ALIGN: begin
            if (stat.div_busy) cmd = fra_pkg::CMD_DIV_STEP;
            else state_in = S_SLICE;
         end
         S_SLICE: begin
            cmd = fra_pkg::CMD_SLICE_STEP;
            if (stat.slice_last) state_in = S_DONE;
         end
         S_DONE: begin
            cmd = fra_pkg::CMD_ALLOC_DONE;
            state_in = S_IDLE;
         end
         S_EDIV: begin
            if (stat.div_busy) cmd = fra_pkg::CMD_DIV_STEP;
            else state_in = S_CLOSE;
         end
         S_CLOSE: begin
            cmd = fra_pkg::CMD_END_CLOSE;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end
endmodule
`default_nettype wire

[hw/rtl/fra_dp.sv]
// fra_dp: datapath of the frame ring allocator: slice table, running offset,
// shared restoring divider, shift-add multiplier and result register.
// Depends on fra_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fra_dp (
   input  wire logic clock,
   input  wire logic reset,
   input  fra_pkg::cmd_type cmd,
   output fra_pkg::status_type stat,
   input  wire logic [31:0] in_alloc_size,
   input  wire logic [16:0] in_alignment,
   input  wire logic [7:0] in_signaled_mask,
   input  wire logic cfg_we,
   input  wire logic [32:0] cfg_data,
   output logic out_valid,
   input  wire logic out_ready,
   output logic [31:0] out_aligned_offset,
   output logic [7:0] out_wait_mask,
   output logic [7:0] out_fenced_mask,
   output logic [32:0] out_used_bytes,
   output logic [1:0] out_status
);
   localparam int N = fra_pkg::SLICE_COUNT;
   localparam int SW = fra_pkg::SLICE_W;

   logic [32:0] buf_ff;
   logic [63:0] run_ff;
   logic [63:0] sstart_ff [N];
   logic [32:0] slen_ff [N];
   logic [N-1:0] inuse_ff, inuse_in;
   logic [SW-1:0] cur_ff;

   logic [33:0] size_ff;     // alloc_size + alignment (zero alignment counts as one)
   logic [16:0] al_ff;
   logic [32:0] off_ff;
   logic [SW-1:0] idx_ff;
   logic [7:0] wait_ff;
   logic fast_ff, nofit_ff;

   // divider: 64-bit dividend by 34-bit divisor, one quotient bit per step
   logic [63:0] dq_ff;       // dividend shifting into quotient
   logic [33:0] drem_ff;
   logic [33:0] dden_ff;
   logic [6:0] dcnt_ff;
   // multiplier: cnt * size, one bit per step
   logic [63:0] macc_ff, mmc_ff, msh_ff;
   logic [6:0] mcnt_ff;

   logic [32:0] bsz;
   always_comb begin
      if (buf_ff == 33'd0) bsz = 33'd1;
      else if (buf_ff > fra_pkg::RING_MAX) bsz = fra_pkg::RING_MAX;
      else bsz = buf_ff;
   end

   logic [34:0] rem_sh;
   logic [34:0] rem_sub;
   always_comb begin
      rem_sh = {drem_ff, dq_ff[63]};
      rem_sub = rem_sh - {1'b0, dden_ff};
   end

   // end frame figures
   logic [63:0] range_w;
   logic [32:0] er_w;
   logic [33:0] sn_er;
   logic wrap_w;
   logic [1:0] need_w;
   logic [N-1:0] freed_w;
   logic [3:0] nfree_w;
   logic [SW-1:0] low1_w, low2_w;
   logic [N-1:0] after1_w;
   always_comb begin
      range_w = run_ff - sstart_ff[cur_ff];
      er_w = (range_w > {31'd0, bsz}) ? bsz : range_w[32:0];
      sn_er = {1'b0, drem_ff[32:0]} + {1'b0, er_w};
      wrap_w = (range_w != 64'd0) && (sn_er > {1'b0, bsz});
      need_w = (range_w == 64'd0) ? 2'd0 : (wrap_w ? 2'd2 : 2'd1);
      freed_w = inuse_ff;
      nfree_w = '0;
      low1_w = '0;
      low2_w = '0;
      for (int i = 0; i < N; i++) begin
         if (!freed_w[i]) nfree_w = nfree_w + 4'd1;
      end
      for (int i = N - 1; i >= 0; i--) begin
         if (!freed_w[i]) low1_w = SW'(i);
      end
      after1_w = freed_w;
      if (wrap_w) after1_w[low1_w] = 1'b1;
      else if (range_w == 64'd0) after1_w[cur_ff] = 1'b0;
      for (int i = N - 1; i >= 0; i--) begin
         if (!after1_w[i]) low2_w = SW'(i);
      end
   end

   always_comb begin
      inuse_in = after1_w;
      inuse_in[low2_w] = 1'b1;
   end

   // overlap test for slice idx_ff
   logic hit_w;
   always_comb begin
      if ({31'd0, off_ff} <= sstart_ff[idx_ff])
         hit_w = ({31'd0, off_ff} + {30'd0, size_ff}) > sstart_ff[idx_ff];
      else
         hit_w = ({1'b0, sstart_ff[idx_ff]} + {32'd0, slen_ff[idx_ff]})
                 > {32'd0, off_ff};
      hit_w = hit_w && inuse_ff[idx_ff] && (idx_ff != cur_ff);
   end

   logic [33:0] o0size;
   assign o0size = {1'b0, drem_ff[32:0]} + size_ff;

   // round-up: (off + al - 1) minus its remainder modulo al
   logic [33:0] al_up_w;
   assign al_up_w = {1'b0, off_ff} + {17'd0, al_ff} - 34'd1 - drem_ff;

   always_comb begin
      stat.div_busy = dcnt_ff != 7'd0;
      stat.mul_busy = mcnt_ff != 7'd0;
      stat.nofit = nofit_ff;
      stat.fast = fast_ff;
      stat.slice_last = idx_ff == SW'(N - 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_ff <= fra_pkg::BUF_RESET;
         run_ff <= '0;
         inuse_ff <= N'(1);
         cur_ff <= '0;
         out_valid <= 1'b0;
         dcnt_ff <= '0;
         mcnt_ff <= '0;
         nofit_ff <= 1'b0;
         for (int i = 0; i < N; i++) begin
            sstart_ff[i] <= '0;
            slen_ff[i] <= '0;
         end
      end else begin
         if (cfg_we) buf_ff <= cfg_data;
         if (out_valid && out_ready) out_valid <= 1'b0;
         unique case (cmd)
            fra_pkg::CMD_ALLOC_SETUP: begin
               al_ff <= (in_alignment == 17'd0) ? 17'd1 : in_alignment;
               size_ff <= {2'b0, in_alloc_size} +
                          ((in_alignment == 17'd0) ? 34'd1 : {17'd0, in_alignment});
               nofit_ff <= ({2'b0, in_alloc_size} +
                  ((in_alignment == 17'd0) ? 34'd1 : {17'd0, in_alignment}))
                  >= {1'b0, bsz};
               if (({2'b0, in_alloc_size} +
                  ((in_alignment == 17'd0) ? 34'd1 : {17'd0, in_alignment}))
                  >= {1'b0, bsz}) begin
                  out_valid <= 1'b1;
                  out_aligned_offset <= '0;
                  out_wait_mask <= '0;
                  out_fenced_mask <= '0;
                  out_used_bytes <= '0;
                  out_status <= fra_pkg::ST_NOFIT;
               end else begin
                  dq_ff <= run_ff;
                  drem_ff <= '0;
                  dden_ff <= {1'b0, bsz};
                  dcnt_ff <= 7'd64;
               end
            end
            fra_pkg::CMD_DIV_STEP: begin
               if (!rem_sub[34]) begin
                  drem_ff <= rem_sub[33:0];
                  dq_ff <= {dq_ff[62:0], 1'b1};
               end else begin
                  drem_ff <= rem_sh[33:0];
                  dq_ff <= {dq_ff[62:0], 1'b0};
               end
               dcnt_ff <= dcnt_ff - 7'd1;
            end
            fra_pkg::CMD_ALLOC_MID: begin
               nofit_ff <= 1'b0;
               if (o0size < {1'b0, bsz}) begin
                  fast_ff <= 1'b1;
                  off_ff <= drem_ff[32:0];
               end else begin
                  fast_ff <= 1'b0;
                  dq_ff <= {30'd0, o0size - {1'b0, bsz}};
                  drem_ff <= '0;
                  dden_ff <= {1'b0, bsz} - size_ff;
                  dcnt_ff <= 7'd64;
               end
            end
            fra_pkg::CMD_ALLOC_POST: begin
               if (!fast_ff) begin
                  off_ff <= drem_ff[32:0];
               end
               macc_ff <= '0;
               mmc_ff <= fast_ff ? 64'd1 : dq_ff + 64'd2;
               msh_ff <= {30'd0, size_ff};
               mcnt_ff <= 7'd64;
            end
            fra_pkg::CMD_MUL_STEP: begin
               if (mmc_ff[0]) macc_ff <= macc_ff + msh_ff;
               mmc_ff <= mmc_ff >> 1;
               msh_ff <= msh_ff << 1;
               mcnt_ff <= (mmc_ff[63:1] == 63'd0) ? 7'd0 : mcnt_ff - 7'd1;
            end
            fra_pkg::CMD_ALIGN_START: begin
               run_ff <= run_ff + macc_ff;
               dq_ff <= {31'd0, off_ff} + {47'd0, al_ff} - 64'd1;
               drem_ff <= '0;
               dden_ff <= {17'd0, al_ff};
               dcnt_ff <= 7'd64;
               idx_ff <= '0;
               wait_ff <= '0;
            end
            fra_pkg::CMD_SLICE_STEP: begin
               wait_ff[idx_ff] <= hit_w;
               idx_ff <= idx_ff + SW'(1);
            end
            fra_pkg::CMD_ALLOC_DONE: begin
               out_valid <= 1'b1;
               out_aligned_offset <= al_up_w[31:0];
               out_wait_mask <= wait_ff;
               out_fenced_mask <= '0;
               out_used_bytes <= '0;
               out_status <= fra_pkg::ST_OK;
            end
            fra_pkg::CMD_END_FREE: begin
               for (int i = 0; i < N; i++) begin
                  if (inuse_ff[i] && SW'(i) != cur_ff && in_signaled_mask[i]) begin
                     inuse_ff[i] <= 1'b0;
                     sstart_ff[i] <= '0;
                     slen_ff[i] <= '0;
                  end
               end
               dq_ff <= sstart_ff[cur_ff];
               drem_ff <= '0;
               dden_ff <= {1'b0, bsz};
               dcnt_ff <= 7'd64;
            end
            fra_pkg::CMD_END_CLOSE: begin
               out_valid <= 1'b1;
               out_aligned_offset <= '0;
               out_wait_mask <= '0;
               if ({2'b0, nfree_w} < {4'd0, need_w}) begin
                  out_fenced_mask <= '0;
                  out_used_bytes <= '0;
                  out_status <= fra_pkg::ST_NOSLICE;
               end else begin
                  out_status <= fra_pkg::ST_OK;
                  out_used_bytes <= (range_w > {31'd0, fra_pkg::USED_MAX}) ?
                                    fra_pkg::USED_MAX : range_w[32:0];
                  if (range_w == 64'd0) begin
                     out_fenced_mask <= '0;
                     // dropped slice may come straight back as the new one
                     if (low2_w != cur_ff) begin
                        sstart_ff[cur_ff] <= '0;
                        slen_ff[cur_ff] <= '0;
                     end
                  end else if (wrap_w) begin
                     sstart_ff[cur_ff] <= {31'd0, drem_ff[32:0]};
                     slen_ff[cur_ff] <= bsz - drem_ff[32:0];
                     sstart_ff[low1_w] <= '0;
                     slen_ff[low1_w] <= er_w - (bsz - drem_ff[32:0]);
                     out_fenced_mask <= (8'd1 << cur_ff) | (8'd1 << low1_w);
                  end else begin
                     sstart_ff[cur_ff] <= {31'd0, drem_ff[32:0]};
                     slen_ff[cur_ff] <= er_w;
                     out_fenced_mask <= 8'd1 << cur_ff;
                  end
                  inuse_ff <= inuse_in;
                  sstart_ff[low2_w] <= run_ff;
                  slen_ff[low2_w] <= '0;
                  cur_ff <= low2_w;
               end
            end
            default: begin
            end
         endcase
      end
   end
endmodule
`default_nettype wire

[tb/sv/tb_frame_ring_allocator.sv]
// tb_frame_ring_allocator: self-checking bench for the frame ring allocator.
// Depends on fra_pkg, fra_if and frame_ring_allocator; checks every answer word
`timescale 1ns / 1ps
module tb_frame_ring_allocator;

   typedef struct packed {
      logic        op;
      logic [31:0] size;
      logic [16:0] align;
      logic [7:0]  sig;
   } alloc_req_type;

   typedef struct packed {
      logic [31:0] offset;
      logic [7:0]  wait_m;
      logic [7:0]  fenced;
      logic [32:0] used;
      logic [1:0]  st;
   } alloc_rsp_type;

   typedef struct {
      alloc_req_type req;
      bit            typed;
      alloc_rsp_type exp;
   } stim_row_type;

   logic clock;
   logic reset;

   fra_if #(.W($bits(alloc_req_type))) req_if ();
   fra_if #(.W($bits(alloc_rsp_type))) rsp_if ();
   fra_if #(.W(33)) csr_if ();

   frame_ring_allocator u_top (
      .clock(clock),
      .reset(reset),
      .req(req_if),
      .rsp(rsp_if),
      .csr(csr_if)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // predictor state
   logic [32:0] ring_reg;
   logic [63:0] run_off;
   logic [63:0] sl_start [fra_pkg::SLICE_COUNT];
   logic [63:0] sl_len [fra_pkg::SLICE_COUNT];
   logic [7:0]  sl_used;
   int unsigned cur_sl;

   alloc_rsp_type pending_rsp[$];
   int errors = 0;
   bit quiet = 0;
   bit hold_rsp = 0;
   int idle_cycles = 0;

   function automatic logic [63:0] ring_eff();
      if (ring_reg == 0) return 64'd1;
      if (ring_reg > fra_pkg::RING_MAX) return {31'd0, fra_pkg::RING_MAX};
      return {31'd0, ring_reg};
   endfunction

   function automatic int unsigned first_free_slice();
      for (int i = 0; i < fra_pkg::SLICE_COUNT; i++)
         if (!sl_used[i]) return i;
      return 0;
   endfunction

   function automatic int unsigned free_slices();
      int unsigned n;
      n = 0;
      for (int i = 0; i < fra_pkg::SLICE_COUNT; i++)
         if (!sl_used[i]) n++;
      return n;
   endfunction

   function automatic alloc_rsp_type predict_alloc(alloc_req_type it);
      alloc_rsp_type r;
      logic [63:0] b, al, span, o0, o1, d, off, cnt, now, s, range, er, sn;
      int unsigned need, sec, nw;
      bit wrap, hit;
      r = '0;
      b = ring_eff();
      al = (it.align == 0) ? 64'd1 : {47'd0, it.align};
      if (it.op == fra_pkg::OP_ALLOC) begin
         span = {32'd0, it.size} + al;
         if (span >= b) begin
            r.st = fra_pkg::ST_NOFIT;
            return r;
         end
         o0 = run_off % b;
         if (o0 + span < b) begin
            off = o0;
            cnt = 1;
         end else begin
            o1 = o0 + span - b;
            d = b - span;
            off = o1 % d;
            cnt = 2 + o1 / d;
         end
         run_off = run_off + cnt * span;
         for (int i = 0; i < fra_pkg::SLICE_COUNT; i++) begin
            if (!sl_used[i] || i == cur_sl) continue;
            if (off <= sl_start[i]) hit = off + span > sl_start[i];
            else hit = sl_start[i] + sl_len[i] > off;
            if (hit) r.wait_m[i] = 1'b1;
         end
         r.offset = 32'(((off + al - 1) / al) * al);
         r.st = fra_pkg::ST_OK;
         return r;
      end
      now = run_off;
      for (int i = 0; i < fra_pkg::SLICE_COUNT; i++) begin
         if (sl_used[i] && i != cur_sl && it.sig[i]) begin
            sl_used[i] = 1'b0;
            sl_start[i] = 0;
            sl_len[i] = 0;
         end
      end
      s = sl_start[cur_sl];
      range = now - s;
      er = (range > b) ? b : range;
      sn = s % b;
      wrap = (range != 0) && (sn + er > b);
      need = (range == 0) ? 0 : (wrap ? 2 : 1);
      if (free_slices() < need) begin
         r.st = fra_pkg::ST_NOSLICE;
         return r;
      end
      if (range == 0) begin
         sl_used[cur_sl] = 1'b0;
         sl_start[cur_sl] = 0;
         sl_len[cur_sl] = 0;
      end else if (wrap) begin
         sl_start[cur_sl] = sn;
         sl_len[cur_sl] = b - sn;
         sec = first_free_slice();
         sl_start[sec] = 0;
         sl_len[sec] = er - (b - sn);
         sl_used[sec] = 1'b1;
         r.fenced[cur_sl] = 1'b1;
         r.fenced[sec] = 1'b1;
      end else begin
         sl_start[cur_sl] = sn;
         sl_len[cur_sl] = er;
         r.fenced[cur_sl] = 1'b1;
      end
      nw = first_free_slice();
      sl_used[nw] = 1'b1;
      sl_start[nw] = now;
      sl_len[nw] = 0;
      cur_sl = nw;
      r.used = (range > {31'd0, fra_pkg::USED_MAX}) ? fra_pkg::USED_MAX : range[32:0];
      r.st = fra_pkg::ST_OK;
      return r;
   endfunction

   task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", field, got, want, $realtime);
      errors++;
   endtask

   // answers are sampled mid-cycle, clear of the edge that changes them
   always @(negedge clock) begin
      alloc_rsp_type got, want;
      if (!reset) begin
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
               || (csr_if.valid && csr_if.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= 5000) begin
            $display("tb: failure");
            $finish;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            got = rsp_if.data;
            if (pending_rsp.size() == 0) begin
               report_mismatch("unexpected word", 64'(got), 64'd0);
            end else begin
               want = pending_rsp.pop_front();
               if (got.offset !== want.offset)
                  report_mismatch("offset", 64'(got.offset), 64'(want.offset));
               if (got.wait_m !== want.wait_m)
                  report_mismatch("wait_mask", 64'(got.wait_m), 64'(want.wait_m));
               if (got.fenced !== want.fenced)
                  report_mismatch("fenced", 64'(got.fenced), 64'(want.fenced));
               if (got.used !== want.used)
                  report_mismatch("used_bytes", 64'(got.used), 64'(want.used));
               if (got.st !== want.st)
                  report_mismatch("status", 64'(got.st), 64'(want.st));
            end
         end
      end
   end

   // response side: random stall bursts, one long hold-off on request
   initial begin
      int n;
      rsp_if.ready = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_if.ready <= 1'b0;
            repeat (700) @(posedge clock);
            hold_rsp = 0;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_if.ready <= 1'b0;
            n = $urandom_range(1, 13);
            repeat (n) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         n = $urandom_range(1, 20);
         repeat (n - 1) @(posedge clock);
      end
   end

   task automatic send_word(alloc_req_type it, bit typed, alloc_rsp_type typed_exp);
      int gap;
      bit hit;
      alloc_rsp_type p;
      gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 13) : 0;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      // operation sits in the low bit, signal mask on top
      req_if.data <= {it.sig, it.align, it.size, it.op};
      do begin
         @(negedge clock);
         hit = req_if.ready;
         @(posedge clock);
      end while (!hit);
      p = predict_alloc(it);
      pending_rsp.push_back(typed ? typed_exp : p);
   endtask

   task automatic write_ring(logic [32:0] v);
      bit hit;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_if.valid <= 1'b1;
      csr_if.data <= v;
      do begin
         @(negedge clock);
         hit = csr_if.ready;
         @(posedge clock);
      end while (!hit);
      csr_if.valid <= 1'b0;
      ring_reg = v;
   endtask

   function automatic alloc_req_type random_word();
      alloc_req_type it;
      logic [63:0] b, lim;
      int unsigned pick;
      b = ring_eff();
      it.op = ($urandom_range(0, 4) == 0) ? fra_pkg::OP_END : fra_pkg::OP_ALLOC;
      pick = $urandom_range(0, 9);
      lim = b / 6;
      if (pick < 7) it.size = (lim == 0) ? 32'd0
         : $urandom_range(0, (lim > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(lim));
      else if (pick < 9) it.size = $urandom_range(0, (b > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF
         : 32'(b));
      else it.size = $urandom;
      pick = $urandom_range(0, 19);
      if (pick < 12) it.align = 17'd1 << $urandom_range(0, 6);
      else if (pick < 17) it.align = 17'($urandom_range(1, 65536));
      else it.align = 17'($urandom);
      pick = $urandom_range(0, 9);
      it.sig = (pick < 4) ? 8'h00 : (pick < 7) ? 8'hFF : 8'($urandom);
      return it;
   endfunction

   initial begin
      stim_row_type rows[$];
      stim_row_type row;
      logic [32:0] ring_list[8];
      ring_list = '{33'd4096, 33'd300, 33'd1, 33'd0, fra_pkg::USED_MAX, fra_pkg::RING_MAX,
         33'd65536, 33'd0};
      ring_list[7] = {1'($urandom_range(0, 1)), 32'($urandom)};

      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.data = '0;
      csr_if.valid = 1'b0;
      csr_if.data = '0;
      ring_reg = fra_pkg::BUF_RESET;
      run_off = 0;
      for (int i = 0; i < fra_pkg::SLICE_COUNT; i++) begin
         sl_start[i] = 0;
         sl_len[i] = 0;
      end
      sl_used = 8'h01;
      cur_sl = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // typed rows: first word after reset and the never-fit cases
      row = '{req: '{fra_pkg::OP_ALLOC, 32'd0, 17'd1, 8'h00}, typed: 1,
         exp: '{32'd0, 8'h00, 8'h00, 33'd0, fra_pkg::ST_OK}};
      rows.push_back(row);
      row = '{req: '{fra_pkg::OP_ALLOC, 32'hFFFF_FFFF, 17'd1, 8'h00}, typed: 1,
         exp: '{32'd0, 8'h00, 8'h00, 33'd0, fra_pkg::ST_NOFIT}};
      rows.push_back(row);
      row = '{req: '{fra_pkg::OP_ALLOC, 32'd16777215, 17'd1, 8'h00}, typed: 1,
         exp: '{32'd0, 8'h00, 8'h00, 33'd0, fra_pkg::ST_NOFIT}};
      rows.push_back(row);
      row.typed = 0;
      row.req = '{fra_pkg::OP_ALLOC, 32'd16777214, 17'd0, 8'h00};   // zero alignment, retry
      rows.push_back(row);
      row.req = '{fra_pkg::OP_ALLOC, 32'd100, 17'd65536, 8'h00};
      rows.push_back(row);
      row.req = '{fra_pkg::OP_ALLOC, 32'd5, 17'h1FFFF, 8'h00};
      rows.push_back(row);
      row.req = '{fra_pkg::OP_END, 32'hFFFF_FFFF, 17'h1FFFF, 8'h00};
      rows.push_back(row);
      row.req = '{fra_pkg::OP_END, 32'd0, 17'd1, 8'h00};            // empty frame dropped
      rows.push_back(row);
      row.req = '{fra_pkg::OP_ALLOC, 32'd10000000, 17'd4096, 8'h00};
      rows.push_back(row);
      row.req = '{fra_pkg::OP_ALLOC, 32'd10000000, 17'd4096, 8'h00};
      rows.push_back(row);
      row.req = '{fra_pkg::OP_END, 32'd0, 17'd1, 8'h00};            // wrapped frame splits
      rows.push_back(row);
      // fill every slice without signals until closing runs out of slices
      for (int k = 0; k < 7; k++) begin
         row.req = '{fra_pkg::OP_ALLOC, 32'd1000, 17'd16, 8'h00};
         rows.push_back(row);
         row.req = '{fra_pkg::OP_END, 32'd0, 17'd1, 8'h00};
         rows.push_back(row);
      end
      row.req = '{fra_pkg::OP_END, 32'd0, 17'd1, 8'hFF};
      rows.push_back(row);
      foreach (rows[k]) send_word(rows[k].req, rows[k].typed, rows[k].exp);
      req_if.valid <= 1'b0;

      for (int ph = 0; ph < 8; ph++) begin
         write_ring(ring_list[ph]);
         if (ph == 0) hold_rsp = 1;
         if (ph == 7) quiet = 1;
         for (int k = 0; k < 135; k++) send_word(random_word(), 0, '0);
         req_if.valid <= 1'b0;
      end

      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule

[frame_ring_allocator.f]
hw/rtl/fra_pkg.sv
hw/rtl/fra_if.sv
hw/rtl/fra_ctrl.sv
hw/rtl/fra_dp.sv
hw/rtl/frame_ring_allocator.sv
tb/sv/tb_frame_ring_allocator.sv
